// ===== src/irdfd_pkg.sv =====
// Shared types and constants for the infrared detector frame decoder.
package irdfd_pkg;

  localparam int BYTE_W  = 8;
  localparam int ADDR_W  = 11;
  localparam int TIME_W  = 32;
  localparam int TMO_W   = 16;
  localparam int IDX_W   = 8;
  localparam int IDX_SPAN = 1 << IDX_W;

  localparam logic [BYTE_W-1:0] SYNC_BYTE     = 8'hFF;
  localparam logic [TMO_W-1:0]  TIMEOUT_RESET = 16'd250;
  localparam logic [1:0]        LAST_HDR_POS  = 2'd2;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_SCAN = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    EV_DETECT  = 2'd0,
    EV_RELEASE = 2'd1,
    EV_BEYOND  = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] loco;
  } det_t;

  typedef struct packed {
    logic             tick;
    logic             scan;
    logic [IDX_W-1:0] idx;
  } req_t;

  typedef struct packed {
    logic              valid;
    event_kind_t       kind;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] loco;
    logic              occ;
  } res_t;

endpackage

// ===== src/ir_detector_frame_decoder.sv =====
// Top level: request register, frame decoder, timeout table and result register.
//
//   port group  direction  handshake            payload
//   request     in         in_valid / in_stall  op, rx_byte, entry_index
//   result      out        out_valid / out_stall event_kind, detector_address,
//                                               loco_code, occupied
//   config      in         cfg_wr_en            cfg_wr_data (release_timeout)
//
// One request per cycle while in_stall is low; once its request is taken, a result
// passes the request register, table read stage and result register in that order.
// The timestamp table read port sets the middle stage.
// Reset clears sync state, counter, valid bits and the timeout to 250.
// in_stall rises only while a stalled result waits and another result is ready.
module ir_detector_frame_decoder
  import irdfd_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [TMO_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        op,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [IDX_W-1:0]  entry_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        event_kind,
  output logic [ADDR_W-1:0] detector_address,
  output logic [BYTE_W-1:0] loco_code,
  output logic              occupied
);

  logic [TMO_W-1:0]  release_timeout;
  logic              s1_valid;
  logic [1:0]        s1_op;
  logic [BYTE_W-1:0] s1_byte;
  logic [IDX_W-1:0]  s1_idx;
  logic              out_hold;
  logic              advance;
  det_t              det;
  req_t              req;
  res_t              res;

  assign out_hold = out_valid && out_stall;
  assign advance  = !(out_hold && res.valid);
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      release_timeout <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      release_timeout <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      s1_op   <= op;
      s1_byte <= rx_byte;
      s1_idx  <= entry_index;
    end
  end

  assign req.tick = s1_valid && s1_op == OP_TICK;
  assign req.scan = s1_valid && s1_op == OP_SCAN;
  assign req.idx  = s1_idx;

  irdfd_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .en      (advance && s1_valid && s1_op == OP_BYTE),
    .rx_byte (s1_byte),
    .det     (det)
  );

  irdfd_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .det             (det),
    .req             (req),
    .release_timeout (release_timeout),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_hold) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_hold) begin
      event_kind       <= res.kind;
      detector_address <= res.addr;
      loco_code        <= res.loco;
      occupied         <= res.occ;
    end
  end

endmodule

// ===== src/irdfd_frame.sv =====
// Byte sync search and 3-byte frame assembly.
module irdfd_frame
  import irdfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [BYTE_W-1:0] rx_byte,
  output det_t              det
);

  logic              in_sync;
  logic [BYTE_W-1:0] previous_byte;
  logic [1:0]        frame_position;
  logic [BYTE_W-1:0] frame_b0;
  logic [BYTE_W-1:0] frame_b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sync        <= 1'b0;
      previous_byte  <= '0;
      frame_position <= '0;
    end else if (en) begin
      previous_byte <= rx_byte;
      if (in_sync) begin
        if (frame_position == LAST_HDR_POS) begin
          frame_position <= '0;
        end else begin
          frame_position <= frame_position + 2'd1;
        end
      end else if (rx_byte == SYNC_BYTE && previous_byte == SYNC_BYTE) begin
        in_sync <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_sync) begin
      if (frame_position == 2'd0) begin
        frame_b0 <= rx_byte;
      end
      if (frame_position == 2'd1) begin
        frame_b1 <= rx_byte;
      end
    end
  end

  always_comb begin
    det.valid = en && in_sync && frame_position == LAST_HDR_POS && frame_b0[0];
    det.addr  = {1'b0, frame_b0[7:1], 3'b000} + {3'b000, frame_b1} + 11'd1;
    det.loco  = rx_byte;
  end

endmodule

// ===== src/irdfd_table.sv =====
// Timestamp table, valid bits, millisecond counter and release check stage.
module irdfd_table
  import irdfd_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  det_t             det,
  input  req_t             req,
  input  logic [TMO_W-1:0] release_timeout,
  output res_t             res
);

  localparam int DEPTH = (TABLE_ENTRIES < IDX_SPAN) ? TABLE_ENTRIES : IDX_SPAN;
  localparam int IW    = $clog2(DEPTH);

  logic [TIME_W-1:0] stamp_mem [DEPTH];
  logic [DEPTH-1:0]  entry_valid;
  logic [DEPTH-1:0]  entry_valid_next;
  logic [TIME_W-1:0] time_now;

  logic              s2_valid;
  logic              s2_scan;
  logic [IW-1:0]     s2_idx;
  event_kind_t       s2_kind;
  logic [ADDR_W-1:0] s2_addr;
  logic [BYTE_W-1:0] s2_loco;
  logic [TIME_W-1:0] s2_stamp;

  logic              det_store;
  logic              det_beyond;
  logic              scan_in_range;
  logic [TIME_W-1:0] elapsed;
  logic              release_hit;

  assign det_store     = 32'(det.addr) < 32'(DEPTH);
  assign det_beyond    = 32'(det.addr) >= 32'(TABLE_ENTRIES);
  assign scan_in_range = 32'(req.idx) < 32'(DEPTH);

  assign elapsed     = time_now - s2_stamp;
  assign release_hit = entry_valid[s2_idx] && (elapsed > {16'b0, release_timeout});

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now <= '0;
    end else if (advance && req.tick) begin
      time_now <= time_now + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && det.valid && det_store) begin
      stamp_mem[det.addr[IW-1:0]] <= time_now;
    end
    if (advance) begin
      s2_stamp <= stamp_mem[req.idx[IW-1:0]];
    end
  end

  always_comb begin
    entry_valid_next = entry_valid;
    if (s2_valid && s2_scan && release_hit) begin
      entry_valid_next[s2_idx] = 1'b0;
    end
    if (det.valid && det_store) begin
      entry_valid_next[det.addr[IW-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (advance) begin
      entry_valid <= entry_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= det.valid || (req.scan && scan_in_range);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_scan <= req.scan;
      s2_idx  <= req.idx[IW-1:0];
      s2_kind <= det_beyond ? EV_BEYOND : EV_DETECT;
      s2_addr <= det.addr;
      s2_loco <= det.loco;
    end
  end

  always_comb begin
    res.valid = s2_valid && (!s2_scan || release_hit);
    if (s2_scan) begin
      res.kind = EV_RELEASE;
      res.addr = ADDR_W'(s2_idx);
      res.loco = '0;
      res.occ  = 1'b0;
    end else begin
      res.kind = s2_kind;
      res.addr = s2_addr;
      res.loco = s2_loco;
      res.occ  = 1'b1;
    end
  end

endmodule
